// ===== rtl/dfacm_pkg.sv =====
// shared types and constants of the class compressed dfa matcher
// no dependencies; imported by dfacm_front, dfacm_back and the top level
package dfacm_pkg;

    // fixed widths of the request and result fields
    localparam int REQ_W  = 3;
    localparam int CHAR_W = 8;
    localparam int SIDX_W = 6;
    localparam int CIDX_W = 5;
    localparam int NXT_W  = 7;
    localparam int CAT_W  = 8;

    // depths of the queue between front and back and of the result queue
    localparam int CMDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 4;

    // request codes on the input channel
    typedef enum logic [REQ_W-1:0] {
        REQ_BYTE     = 3'd0,
        REQ_END      = 3'd1,
        REQ_CLASS_WR = 3'd2,
        REQ_TRANS_WR = 3'd3,
        REQ_INFO_WR  = 3'd4
    } t_req;

    // operations handed from front to back
    typedef enum logic [1:0] {
        OP_BYTE,
        OP_END,
        OP_TRANS_WR,
        OP_INFO_WR
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic                     alpha;
        logic [CIDX_W-1:0]        cls;
        logic [SIDX_W-1:0]        sidx;
        logic signed [NXT_W-1:0]  nxt;
        logic                     acc;
        logic [CAT_W-1:0]         cat;
    } t_cmd;

    typedef struct packed {
        logic             accepted;
        logic [CAT_W-1:0] category;
    } t_res;

    // back end sequencer: clearing pass over the state info table, then run
    typedef enum logic {
        BS_CLEAR,
        BS_RUN
    } t_bstate;

endpackage

// ===== rtl/dfacm_fifo.sv =====
// small register queue used between front and back and for results
// depends on nothing but its parameters
module dfacm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_rd,
    output logic [WIDTH-1:0]                 o_rdata,
    output logic                             o_empty,
    output logic                             o_full,
    output logic [$clog2(DEPTH+1)-1:0]       o_cnt
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_rdata = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/dfacm_front.sv =====
// front end: accepts requests, owns the byte class table, drops ignored writes
// depends on dfacm_pkg; feeds the command queue toward dfacm_back
module dfacm_front
    import dfacm_pkg::*;
#(
    parameter int MAX_STATES  = 64,
    parameter int MAX_CLASSES = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic                     i_hold,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [CHAR_W-1:0]        i_char_byte,
    input  logic [SIDX_W-1:0]        i_state_index,
    input  logic [CIDX_W-1:0]        i_class_index,
    input  logic signed [NXT_W-1:0]  i_next_state,
    input  logic                     i_in_alphabet,
    input  logic                     i_accepting,
    input  logic [CAT_W-1:0]         i_category,
    output logic                     o_cmd_wr,
    output t_cmd                     o_cmd,
    input  logic                     i_cmd_full
);

    localparam int NCHAR = 1 << CHAR_W;

    // class entry: in-alphabet bit above the class number
    logic [CIDX_W:0]   r_cls_mem [NCHAR];
    logic [NCHAR-1:0]  r_cls_vld;
    logic [CIDX_W:0]   r_crd;
    logic              r_crd_v;

    logic  r_s1_valid;
    t_cmd  r_s1;

    logic  accept;
    logic  sidx_ok;
    logic  cidx_ok;
    logic  n_keep;
    t_op   n_op;
    logic  cls_we;

    assign o_full   = i_hold | (r_s1_valid & i_cmd_full);
    assign accept   = i_push & ~o_full;
    assign o_cmd_wr = r_s1_valid & ~i_cmd_full;

    assign sidx_ok = (32'(i_state_index) < MAX_STATES);
    assign cidx_ok = (32'(i_class_index) < MAX_CLASSES);

    always_comb begin
        n_keep = 1'b0;
        n_op   = OP_BYTE;
        cls_we = 1'b0;
        unique case (i_req_type)
            REQ_BYTE: begin
                n_keep = 1'b1;
                n_op   = OP_BYTE;
            end
            REQ_END: begin
                n_keep = 1'b1;
                n_op   = OP_END;
            end
            REQ_CLASS_WR: begin
                cls_we = cidx_ok;
            end
            REQ_TRANS_WR: begin
                n_keep = sidx_ok & cidx_ok;
                n_op   = OP_TRANS_WR;
            end
            REQ_INFO_WR: begin
                n_keep = sidx_ok;
                n_op   = OP_INFO_WR;
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    // class table: registered read, valid bits cleared by reset
    always_ff @(posedge i_clk) begin
        if (accept && cls_we) begin
            r_cls_mem[i_char_byte] <= {i_in_alphabet, i_class_index};
        end
        if (accept) begin
            r_crd   <= r_cls_mem[i_char_byte];
            r_crd_v <= r_cls_vld[i_char_byte];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls_vld <= '0;
        end else if (accept && cls_we) begin
            r_cls_vld[i_char_byte] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= n_keep;
        end else if (o_cmd_wr) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.op    <= n_op;
            r_s1.alpha <= 1'b0;
            r_s1.cls   <= i_class_index;
            r_s1.sidx  <= i_state_index;
            r_s1.nxt   <= i_next_state;
            r_s1.acc   <= i_accepting;
            r_s1.cat   <= i_category;
        end
    end

    // string bytes take their class from the table read
    always_comb begin
        o_cmd = r_s1;
        if (r_s1.op == OP_BYTE) begin
            o_cmd.alpha = r_crd_v & r_crd[CIDX_W];
            o_cmd.cls   = r_crd[CIDX_W-1:0];
        end
    end

endmodule

// ===== rtl/dfacm_back.sv =====
// back end: transition and state info tables, state walk and end reports
// depends on dfacm_pkg; pops the command queue, writes the result queue
module dfacm_back
    import dfacm_pkg::*;
#(
    parameter int MAX_STATES  = 64,
    parameter int MAX_CLASSES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_cmd                                i_cmd,
    input  logic                                i_cmd_empty,
    output logic                                o_cmd_rd,
    input  logic [$clog2(OUTQ_DEPTH+1)-1:0]     i_out_cnt,
    output logic                                o_res_wr,
    output t_res                                o_res,
    output logic                                o_clearing
);

    localparam int STATE_W = $clog2(MAX_STATES);
    localparam int CLASS_W = $clog2(MAX_CLASSES);
    localparam int TADDR_W = STATE_W + CLASS_W;
    localparam int TDEPTH  = MAX_STATES << CLASS_W;

    logic [NXT_W-1:0]   r_tmem [TDEPTH];
    logic [CAT_W:0]     r_imem [MAX_STATES];
    logic [NXT_W-1:0]   r_tdata;
    logic [CAT_W:0]     r_idata;

    t_bstate            r_bstate;
    t_bstate            n_bstate;
    logic [STATE_W-1:0] r_clr_idx;
    logic [STATE_W-1:0] r_state;
    logic               r_rej;
    logic               r_pend;
    logic               r_end_v;
    logic               r_end_rej;

    logic               clr_we;
    logic               running;
    logic               dead;
    logic               eff_rej;
    logic [STATE_W-1:0] eff_state;
    logic               is_end;
    logic               is_byte;
    logic               out_busy;
    logic               tbl_rd;
    logic               tbl_wr;
    logic [TADDR_W-1:0] tbl_raddr;
    logic [TADDR_W-1:0] tbl_waddr;
    logic               info_we;
    logic [STATE_W-1:0] info_waddr;
    logic [CAT_W:0]     info_wdata;

    always_comb begin
        n_bstate = r_bstate;
        unique case (r_bstate)
            BS_CLEAR: begin
                if (r_clr_idx == STATE_W'(MAX_STATES - 1)) begin
                    n_bstate = BS_RUN;
                end
            end
            BS_RUN: begin
                n_bstate = BS_RUN;
            end
            default: begin
                n_bstate = BS_CLEAR;
            end
        endcase
    end

    always_comb begin
        clr_we  = 1'b0;
        running = 1'b0;
        unique case (r_bstate)
            BS_CLEAR: clr_we  = 1'b1;
            BS_RUN:   running = 1'b1;
            default:  clr_we  = 1'b0;
        endcase
    end

    assign o_clearing = clr_we;

    // fold the outcome of the last transition read into the walk state
    assign dead      = r_tdata[NXT_W-1] | (32'(r_tdata) >= MAX_STATES);
    assign eff_rej   = r_rej | (r_pend & dead);
    assign eff_state = r_pend ? STATE_W'(r_tdata) : r_state;

    assign is_end   = (i_cmd.op == OP_END);
    assign is_byte  = (i_cmd.op == OP_BYTE);
    assign out_busy = (32'(i_out_cnt) + 32'(r_end_v)) >= OUTQ_DEPTH;
    assign o_cmd_rd = running & ~i_cmd_empty & ~(is_end & out_busy);

    assign tbl_rd    = o_cmd_rd & is_byte & ~eff_rej & i_cmd.alpha;
    assign tbl_raddr = {eff_state, CLASS_W'(i_cmd.cls)};
    assign tbl_wr    = o_cmd_rd & (i_cmd.op == OP_TRANS_WR);
    assign tbl_waddr = {STATE_W'(i_cmd.sidx), CLASS_W'(i_cmd.cls)};

    assign info_we    = clr_we | (o_cmd_rd & (i_cmd.op == OP_INFO_WR));
    assign info_waddr = clr_we ? r_clr_idx : STATE_W'(i_cmd.sidx);
    assign info_wdata = clr_we ? '0 : {i_cmd.acc, i_cmd.cat};

    always_ff @(posedge i_clk) begin
        if (tbl_wr) begin
            r_tmem[tbl_waddr] <= i_cmd.nxt;
        end
        if (tbl_rd) begin
            r_tdata <= r_tmem[tbl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (info_we) begin
            r_imem[info_waddr] <= info_wdata;
        end
        if (o_cmd_rd && is_end) begin
            r_idata <= r_imem[eff_state];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate  <= BS_CLEAR;
            r_clr_idx <= '0;
            r_state   <= '0;
            r_rej     <= 1'b0;
            r_pend    <= 1'b0;
            r_end_v   <= 1'b0;
        end else begin
            r_bstate <= n_bstate;
            if (clr_we) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            r_end_v <= o_cmd_rd & is_end;
            r_pend  <= tbl_rd;
            // end of string returns to the start state; a byte outside
            // the alphabet rejects the rest of the string
            if (o_cmd_rd && is_end) begin
                r_state <= '0;
                r_rej   <= 1'b0;
            end else begin
                r_state <= eff_state;
                r_rej   <= eff_rej | (o_cmd_rd & is_byte & ~i_cmd.alpha);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_rd && is_end) begin
            r_end_rej <= eff_rej;
        end
    end

    assign o_res_wr          = r_end_v;
    assign o_res.accepted    = ~r_end_rej & r_idata[CAT_W];
    assign o_res.category    = o_res.accepted ? r_idata[CAT_W-1:0] : '0;

endmodule

// ===== rtl/class_compressed_dfa_matcher.sv =====
// top level of the class compressed dfa matcher
// depends on dfacm_pkg, dfacm_front, dfacm_fifo and dfacm_back
//
// table-driven dfa token classifier with a queue interface on both sides;
// each request either writes a table entry or feeds the string being matched,
// and only an end-of-string request yields a result (accepted, category);
// one request per cycle is sustained while full is low: the byte class
// lookup sits in the front and the only state-dependent step, one read of
// the transition table whose registered output addresses the next read,
// sits in the back; an end request passes the front stage register and the
// command queue, its result is registered in the back and queued; after reset
// the state info table is cleared entry by entry while full stays high;
// transition entries must be written before they are used
module class_compressed_dfa_matcher
    import dfacm_pkg::*;
#(
    parameter int MAX_STATES  = 64,
    parameter int MAX_CLASSES = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request side
    input  logic                     push,
    output logic                     full,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [CHAR_W-1:0]        i_char_byte,
    input  logic [SIDX_W-1:0]        i_state_index,
    input  logic [CIDX_W-1:0]        i_class_index,
    input  logic signed [NXT_W-1:0]  i_next_state,
    input  logic                     i_in_alphabet,
    input  logic                     i_accepting,
    input  logic [CAT_W-1:0]         i_category,
    // result side
    output logic                     empty,
    input  logic                     pop,
    output logic                     o_accepted,
    output logic [CAT_W-1:0]         o_token_category
);

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_res);

    // front to command queue
    logic                               cmd_wr;
    t_cmd                               cmd_wdata;
    logic                               cmdq_full;
    logic                               cmdq_empty;
    logic [$clog2(CMDQ_DEPTH+1)-1:0]    cmdq_cnt;
    logic [CMD_W-1:0]                   cmd_rdata;
    t_cmd                               cmd_head;
    logic                               cmd_rd;

    // back to result queue
    logic                               res_wr;
    t_res                               res_wdata;
    logic                               outq_full;
    logic [$clog2(OUTQ_DEPTH+1)-1:0]    outq_cnt;
    logic [RES_W-1:0]                   res_rdata;
    t_res                               res_head;
    logic                               res_rd;

    logic                               clearing;

    // front: class lookup, request decode, filtering of ignored writes
    dfacm_front #(
        .MAX_STATES  (MAX_STATES),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_hold        (clearing),
        .i_req_type    (i_req_type),
        .i_char_byte   (i_char_byte),
        .i_state_index (i_state_index),
        .i_class_index (i_class_index),
        .i_next_state  (i_next_state),
        .i_in_alphabet (i_in_alphabet),
        .i_accepting   (i_accepting),
        .i_category    (i_category),
        .o_cmd_wr      (cmd_wr),
        .o_cmd         (cmd_wdata),
        .i_cmd_full    (cmdq_full)
    );

    // decoupling queue so front and back stall independently
    dfacm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wdata (cmd_wdata),
        .i_rd    (cmd_rd),
        .o_rdata (cmd_rdata),
        .o_empty (cmdq_empty),
        .o_full  (cmdq_full),
        .o_cnt   (cmdq_cnt)
    );

    assign cmd_head = t_cmd'(cmd_rdata);

    // back: state walk over the transition table and end-of-string reports
    dfacm_back #(
        .MAX_STATES  (MAX_STATES),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmdq_empty),
        .o_cmd_rd    (cmd_rd),
        .i_out_cnt   (outq_cnt),
        .o_res_wr    (res_wr),
        .o_res       (res_wdata),
        .o_clearing  (clearing)
    );

    // result queue, the consumer pops from its head
    dfacm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (res_wdata),
        .i_rd    (res_rd),
        .o_rdata (res_rdata),
        .o_empty (empty),
        .o_full  (outq_full),
        .o_cnt   (outq_cnt)
    );

    assign res_rd           = pop & ~empty;
    assign res_head         = t_res'(res_rdata);
    assign o_accepted       = res_head.accepted;
    assign o_token_category = res_head.category;

`ifndef SYNTH
    // the back only reports when the result queue has room reserved
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_wr |-> !outq_full)
        else $error("result written into a full result queue");

    // the front only forwards a request when the command queue has room
    a_cmd_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_wr |-> (!cmdq_full && (cmdq_cnt < CMDQ_DEPTH)))
        else $error("request forwarded into a full command queue");

    // no request runs while the state info table is being cleared
    a_clear_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (!cmd_rd && full))
        else $error("request taken during the clearing pass");

    // the clearing pass starts right after reset
    a_clear_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> clearing)
        else $error("clearing pass did not start after reset");
`endif

endmodule

// ===== tb/dfacm_tb_pkg.sv =====
// request record and result scoreboard for the dfa matcher testbench
// depends on dfacm_pkg for field widths, request codes and the result type
`timescale 1ns / 100ps

package dfacm_tb_pkg;
    import dfacm_pkg::*;

    localparam int N_STATES  = 64;
    localparam int N_CLASSES = 32;
    localparam int ALPHA_BIT = CIDX_W;

    // codes past the last defined request
    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

    localparam logic signed [NXT_W-1:0] DEAD_TARGET = -7'sd1;

    typedef struct {
        logic [REQ_W-1:0]        req_type;
        logic [CHAR_W-1:0]       char_byte;
        logic [SIDX_W-1:0]       state_index;
        logic [CIDX_W-1:0]       class_index;
        logic signed [NXT_W-1:0] next_state;
        logic                    in_alphabet;
        logic                    accepting;
        logic [CAT_W-1:0]        category;
    } t_dfa_req;

    class match_scoreboard;
        // shadow copy of the matcher tables and string state
        logic [CIDX_W:0]         class_map [256];
        logic signed [NXT_W-1:0] trans_tab [N_STATES][N_CLASSES];
        bit                      trans_known [N_STATES][N_CLASSES];
        bit                      state_acc [N_STATES];
        logic [CAT_W-1:0]        state_cat [N_STATES];
        logic [SIDX_W-1:0]       cur_state;
        bit                      rejected;
        t_res                    verdict_q [$];
        int                      fail_count;

        function new();
            for (int b = 0; b < 256; b++) class_map[b] = '0;
            for (int s = 0; s < N_STATES; s++) begin
                state_acc[s] = 1'b0;
                state_cat[s] = '0;
                for (int c = 0; c < N_CLASSES; c++) begin
                    trans_tab[s][c]   = '0;
                    trans_known[s][c] = 1'b0;
                end
            end
            cur_state  = '0;
            rejected   = 1'b0;
            fail_count = 0;
        endfunction

        function void advance_on_char(logic [CHAR_W-1:0] ch);
            logic [CIDX_W:0]         entry;
            logic signed [NXT_W-1:0] tgt;
            if (rejected) return;
            entry = class_map[ch];
            if (!entry[ALPHA_BIT]) begin
                rejected = 1'b1;
                return;
            end
            tgt = trans_tab[cur_state][entry[CIDX_W-1:0]];
            // sign bit covers both the dead code and targets past the last state
            if (tgt[NXT_W-1]) rejected = 1'b1;
            else cur_state = tgt[SIDX_W-1:0];
        endfunction

        function void note_request(t_dfa_req r);
            t_res v;
            case (r.req_type)
                REQ_BYTE: advance_on_char(r.char_byte);
                REQ_END: begin
                    v.accepted = 1'b0;
                    v.category = '0;
                    if (!rejected && state_acc[cur_state]) begin
                        v.accepted = 1'b1;
                        v.category = state_cat[cur_state];
                    end
                    verdict_q = {verdict_q, v};
                    cur_state = '0;
                    rejected  = 1'b0;
                end
                REQ_CLASS_WR: class_map[r.char_byte] = {r.in_alphabet, r.class_index};
                REQ_TRANS_WR: begin
                    trans_tab[r.state_index][r.class_index]   = r.next_state;
                    trans_known[r.state_index][r.class_index] = 1'b1;
                end
                REQ_INFO_WR: begin
                    state_acc[r.state_index] = r.accepting;
                    state_cat[r.state_index] = r.category;
                end
                default: ;
            endcase
        endfunction

        function void check_verdict(logic acc, logic [CAT_W-1:0] cat);
            t_res exp_v;
            if (verdict_q.size() == 0) begin
                $error("unexpected result: accepted=%0d token_category=%0d", acc, cat);
                fail_count++;
                return;
            end
            exp_v = verdict_q.pop_front();
            if (acc !== exp_v.accepted) begin
                $error("accepted: expected %0d, got %0d", exp_v.accepted, acc);
                fail_count++;
            end
            if (cat !== exp_v.category) begin
                $error("token_category: expected %0d, got %0d", exp_v.category, cat);
                fail_count++;
            end
        endfunction

        function int verdicts_pending();
            return verdict_q.size();
        endfunction
    endclass

endpackage

// ===== tb/tb_class_compressed_dfa_matcher.sv =====
// testbench top for the class compressed dfa matcher
// depends on dfacm_pkg, dfacm_tb_pkg and the class_compressed_dfa_matcher rtl
// directed table and string checks, then random table loads and strings
`timescale 1ns / 100ps

module tb_class_compressed_dfa_matcher;
    import dfacm_pkg::*;
    import dfacm_tb_pkg::*;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic [REQ_W-1:0]        i_req_type;
    logic [CHAR_W-1:0]       i_char_byte;
    logic [SIDX_W-1:0]       i_state_index;
    logic [CIDX_W-1:0]       i_class_index;
    logic signed [NXT_W-1:0] i_next_state;
    logic                    i_in_alphabet;
    logic                    i_accepting;
    logic [CAT_W-1:0]        i_category;
    logic                    empty;
    logic                    pop;
    logic                    o_accepted;
    logic [CAT_W-1:0]        o_token_category;

    match_scoreboard sb = new();

    // idle odds in percent, changed between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // requests with a defined code, for pacing the random part
    int requests_sent  = 0;

    class_compressed_dfa_matcher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_req_type      (i_req_type),
        .i_char_byte     (i_char_byte),
        .i_state_index   (i_state_index),
        .i_class_index   (i_class_index),
        .i_next_state    (i_next_state),
        .i_in_alphabet   (i_in_alphabet),
        .i_accepting     (i_accepting),
        .i_category      (i_category),
        .empty           (empty),
        .pop             (pop),
        .o_accepted      (o_accepted),
        .o_token_category(o_token_category)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("class_compressed_dfa_matcher verification failed");
        $finish;
    end

    // result side: random stalls on pop, check each popped result
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) sb.check_verdict(o_accepted, o_token_category);
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // every field random, request code across the whole 3-bit range
    function automatic t_dfa_req random_fill();
        t_dfa_req r;
        r.req_type    = REQ_W'($urandom_range(0, REQ_UNUSED_LAST));
        r.char_byte   = CHAR_W'($urandom_range(0, 255));
        r.state_index = SIDX_W'($urandom_range(0, N_STATES - 1));
        r.class_index = CIDX_W'($urandom_range(0, N_CLASSES - 1));
        r.next_state  = NXT_W'($urandom_range(0, 127));
        r.in_alphabet = 1'($urandom_range(0, 1));
        r.accepting   = 1'($urandom_range(0, 1));
        r.category    = CAT_W'($urandom_range(0, 255));
        return r;
    endfunction

    // transition target: mostly low states so strings revisit written entries
    function automatic logic signed [NXT_W-1:0] pick_target();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75) return NXT_W'($urandom_range(0, 15));
        if (roll < 87) return NXT_W'($urandom_range(0, N_STATES - 1));
        if (roll < 93) return DEAD_TARGET;
        // top bit set: any negative code, past-the-last-state codes included
        return NXT_W'($urandom_range(64, 127));
    endfunction

    // one request through push/full; push stays high into the next request
    // unless an idle cycle is drawn
    task automatic send_item(input t_dfa_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_req_type    <= r.req_type;
        i_char_byte   <= r.char_byte;
        i_state_index <= r.state_index;
        i_class_index <= r.class_index;
        i_next_state  <= r.next_state;
        i_in_alphabet <= r.in_alphabet;
        i_accepting   <= r.accepting;
        i_category    <= r.category;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(r);
        if (r.req_type < REQ_UNUSED_FIRST) requests_sent++;
    endtask

    task automatic send_fields(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                               input logic [SIDX_W-1:0] sidx, input logic [CIDX_W-1:0] cidx,
                               input logic signed [NXT_W-1:0] nxt, input logic alpha,
                               input logic acc, input logic [CAT_W-1:0] cat);
        t_dfa_req r;
        r.req_type    = req;
        r.char_byte   = ch;
        r.state_index = sidx;
        r.class_index = cidx;
        r.next_state  = nxt;
        r.in_alphabet = alpha;
        r.accepting   = acc;
        r.category    = cat;
        send_item(r);
    endtask

    // string byte; a live string on an in-alphabet byte reads the transition
    // table, so an entry never written gets written just before
    task automatic feed_char(input logic [CHAR_W-1:0] ch);
        t_dfa_req        r;
        logic [CIDX_W:0] entry;
        entry = sb.class_map[ch];
        if (!sb.rejected && entry[ALPHA_BIT]
                && !sb.trans_known[sb.cur_state][entry[CIDX_W-1:0]]) begin
            r             = random_fill();
            r.req_type    = REQ_TRANS_WR;
            r.state_index = sb.cur_state;
            r.class_index = entry[CIDX_W-1:0];
            r.next_state  = pick_target();
            send_item(r);
        end
        r           = random_fill();
        r.req_type  = REQ_BYTE;
        r.char_byte = ch;
        send_item(r);
    endtask

    // sender holds off until every pending result has been popped
    task automatic hold_until_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.verdicts_pending() != 0);
    endtask

    task automatic run_directed();
        // empty string right after reset: start state does not accept
        send_fields(REQ_END, 8'h00, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        // small alphabet, extreme byte and class values
        send_fields(REQ_CLASS_WR, 8'h61, '0, 5'd1, '0, 1'b1, 1'b0, 8'h00);
        send_fields(REQ_CLASS_WR, 8'hff, '0, 5'd31, '0, 1'b1, 1'b0, 8'h00);
        send_fields(REQ_CLASS_WR, 8'h00, '0, 5'd0, '0, 1'b0, 1'b0, 8'h00);
        // 0 -a-> 1 -ff-> 63 -ff-> dead; 1 -a-> past the last state
        send_fields(REQ_TRANS_WR, 8'h00, 6'd0, 5'd1, 7'sd1, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_TRANS_WR, 8'h00, 6'd1, 5'd31, 7'sd63, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_TRANS_WR, 8'h00, 6'd63, 5'd31, DEAD_TARGET, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_TRANS_WR, 8'h00, 6'd1, 5'd1, 7'h40, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_INFO_WR, 8'h00, 6'd1, '0, '0, 1'b0, 1'b1, 8'hff);
        send_fields(REQ_INFO_WR, 8'h00, 6'd63, '0, '0, 1'b0, 1'b1, 8'h5a);
        // accepted in state 1
        send_fields(REQ_BYTE, 8'h61, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_END, 8'h00, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        // accepted in state 63
        send_fields(REQ_BYTE, 8'h61, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_BYTE, 8'hff, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_END, 8'h00, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        // dead transition out of 63
        send_fields(REQ_BYTE, 8'h61, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_BYTE, 8'hff, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_BYTE, 8'hff, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_END, 8'h00, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        // byte outside the alphabet, later in-alphabet byte ignored
        send_fields(REQ_BYTE, 8'h00, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_BYTE, 8'h61, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_END, 8'h00, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        // target past the last state rejects
        send_fields(REQ_BYTE, 8'h61, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_BYTE, 8'h61, '0, '0, '0, 1'b0, 1'b0, 8'h00);
        send_fields(REQ_END, 8'h00, '0, '0, '0, 1'b0, 1'b0, 8'h00);
    endtask

    // mostly whole strings, with bursts of table loads and some noise in between
    task automatic random_traffic(input int n_items);
        t_dfa_req          r;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] alpha_bytes [$];
        int                stop_at;
        int                kind;
        int                len;
        int                roll;
        stop_at = requests_sent + n_items;
        while (requests_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                // burst of table writes, biased toward a compact machine
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    r    = random_fill();
                    roll = $urandom_range(99);
                    if (roll < 45) begin
                        r.req_type    = REQ_CLASS_WR;
                        r.in_alphabet = ($urandom_range(99) < 80);
                        if ($urandom_range(99) < 70)
                            r.class_index = CIDX_W'($urandom_range(0, 7));
                    end else if (roll < 75) begin
                        r.req_type = REQ_INFO_WR;
                        if ($urandom_range(99) < 70)
                            r.state_index = SIDX_W'($urandom_range(0, 15));
                    end else begin
                        r.req_type = REQ_TRANS_WR;
                        if ($urandom_range(99) < 70) begin
                            r.state_index = SIDX_W'($urandom_range(0, 15));
                            r.class_index = CIDX_W'($urandom_range(0, 7));
                        end
                        r.next_state = pick_target();
                    end
                    send_item(r);
                end
            end else if (kind < 85) begin
                // well-formed string: bytes mostly from the current alphabet
                alpha_bytes.delete();
                for (int b = 0; b < 256; b++)
                    if (sb.class_map[b][ALPHA_BIT]) alpha_bytes = {alpha_bytes, CHAR_W'(b)};
                len = $urandom_range(0, 8);
                for (int i = 0; i < len; i++) begin
                    if (alpha_bytes.size() != 0 && $urandom_range(99) < 90)
                        ch = alpha_bytes[$urandom_range(0, alpha_bytes.size() - 1)];
                    else
                        ch = CHAR_W'($urandom_range(0, 255));
                    feed_char(ch);
                end
                r          = random_fill();
                r.req_type = REQ_END;
                send_item(r);
            end else begin
                // noise: any code, unused ones included
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    r = random_fill();
                    if (r.req_type == REQ_BYTE) feed_char(r.char_byte);
                    else send_item(r);
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_req_type    = '0;
        i_char_byte   = '0;
        i_state_index = '0;
        i_class_index = '0;
        i_next_state  = '0;
        i_in_alphabet = 1'b0;
        i_accepting   = 1'b0;
        i_category    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // no idling
        random_traffic(130);

        // sender mostly idle
        hold_until_drained();
        send_idle_pct = 70;
        random_traffic(130);

        // receiver mostly stalled
        hold_until_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        random_traffic(130);

        // light idling on both sides
        hold_until_drained();
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        random_traffic(110);

        push <= 1'b0;
        while (sb.verdicts_pending() != 0) @(posedge i_clk);
        // let any stray result surface
        repeat (16) @(posedge i_clk);

        if (sb.fail_count == 0)
            $display("class_compressed_dfa_matcher verification clean");
        else
            $display("class_compressed_dfa_matcher verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dfacm_pkg.sv
rtl/dfacm_fifo.sv
rtl/dfacm_front.sv
rtl/dfacm_back.sv
rtl/class_compressed_dfa_matcher.sv
tb/dfacm_tb_pkg.sv
tb/tb_class_compressed_dfa_matcher.sv
